// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the range max table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Types, codes and control structs of the 2D sparse table range max block.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_LEVELS   = 7;

    typedef logic [5:0] t_coord;
    typedef logic [7:0] t_value;
    typedef logic [6:0] t_cfg_val;
    typedef logic       t_op;
    typedef logic       t_cfg_idx;

    localparam t_op OP_LOAD  = 1'b0;
    localparam t_op OP_QUERY = 1'b1;

    localparam t_cfg_idx CFG_NUM_ROWS = 1'b0;
    localparam t_cfg_idx CFG_NUM_COLS = 1'b1;

    localparam t_cfg_val CFG_RESET_DIM = 7'd64;

    // read address source of the table memory
    localparam logic [1:0] RD_BUILD = 2'd0;
    localparam logic [1:0] RD_Q0    = 2'd1;
    localparam logic [1:0] RD_Q1    = 2'd2;

    typedef struct packed {
        logic       in_ready;
        logic       build_init;
        logic       build_wr;
        logic       set_ready;
        logic       clr_ready;
        logic       rd_en;
        logic [1:0] rd_mode;
        logic       acc_load;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_query;
        logic in_last;
        logic build_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/rmst_if.sv =====
// ----------------------------------------------------------------------------
// rmst interfaces
// Item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmst_in_if;
    import rmst_pkg::*;
    logic   valid;
    logic   ready;
    t_op    operation;
    t_coord row_a;
    t_coord col_a;
    t_coord row_b;
    t_coord col_b;
    t_value cell_value;
    logic   last_cell;

    modport source (output valid, operation, row_a, col_a, row_b, col_b, cell_value,
                    last_cell, input ready);
    modport sink (input valid, operation, row_a, col_a, row_b, col_b, cell_value,
                  last_cell, output ready);
endinterface

interface rmst_out_if;
    import rmst_pkg::*;
    logic   valid;
    logic   ready;
    t_value max_value;
    logic   error;

    modport source (output valid, max_value, error, input ready);
    modport sink (input valid, max_value, error, output ready);
endinterface

interface rmst_cfg_if;
    import rmst_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_cfg_val data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for load, table build and query of the range max block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rmst_pkg::t_stat i_stat,
    output rmst_pkg::t_cmd  o_cmd
);
    import rmst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BRD   = 3'd1;
    localparam logic [2:0] S_BWR   = 3'd2;
    localparam logic [2:0] S_QRD0  = 3'd3;
    localparam logic [2:0] S_QRD1  = 3'd4;
    localparam logic [2:0] S_QDONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign w_accept = i_stat.in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    if (i_stat.in_query) begin
                        n_state = S_QRD0;
                    end else if (i_stat.in_last) begin
                        o_cmd.build_init = 1'b1;
                        n_state          = S_BRD;
                    end else begin
                        o_cmd.clr_ready = 1'b1;
                    end
                end
            end
            S_BRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_mode = RD_BUILD;
                n_state       = S_BWR;
            end
            S_BWR: begin
                o_cmd.rd_mode  = RD_BUILD;
                o_cmd.build_wr = 1'b1;
                if (i_stat.build_last) begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_QRD0: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_mode = RD_Q0;
                n_state       = S_QRD1;
            end
            S_QRD1: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_mode  = RD_Q1;
                o_cmd.acc_load = 1'b1;
                n_state        = S_QDONE;
            end
            S_QDONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RMST_ASSERT_NXT(a_load_done, i_clk, i_rst_n, w_accept && !i_stat.in_query && !i_stat.in_last, r_state == S_IDLE, "plain load did not finish in one cycle")
    `RMST_ASSERT_NXT(a_query_start, i_clk, i_rst_n, w_accept && i_stat.in_query, r_state == S_QRD0, "query did not start reading")
    `RMST_ASSERT_NXT(a_build_end, i_clk, i_rst_n, (r_state == S_BWR) && i_stat.build_last, r_state == S_IDLE, "build did not end after last entry")

endmodule

// ===== hdl/rmst_dpath.sv =====
// ----------------------------------------------------------------------------
// rmst_dpath
// Grid and table memories, build counters, query address logic, result reg.
// ----------------------------------------------------------------------------
module rmst_dpath #(
    parameter int MAX_ROWS = rmst_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rmst_pkg::DEF_MAX_COLS,
    parameter int LEVELS   = rmst_pkg::DEF_LEVELS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rmst_pkg::t_cmd  i_cmd,
    output rmst_pkg::t_stat o_stat,
    rmst_in_if.sink         i_item,
    rmst_out_if.source      o_result,
    rmst_cfg_if.sink        i_cfg
);
    import rmst_pkg::*;

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int GDEPTH = MAX_ROWS * MAX_COLS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int TDEPTH = MAX_ROWS * LEVELS * MAX_COLS * LEVELS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

    function automatic logic [TAW-1:0] tab_idx(input logic [RW-1:0] r, input logic [LW-1:0] k,
                                               input logic [CW-1:0] c, input logic [LW-1:0] l);
        return TAW'(((32'(r) * LEVELS + 32'(k)) * MAX_COLS + 32'(c)) * LEVELS + 32'(l));
    endfunction

    function automatic logic [2:0] floor_log2(input logic [6:0] v);
        logic [2:0] res;
        res = 3'd0;
        for (int b = 1; b < 7; b++) begin
            if (v[b]) res = 3'(b);
        end
        return res;
    endfunction

    function automatic logic [LW-1:0] lvl_clamp(input logic [2:0] v);
        if (32'(v) > LEVELS - 1) return LW'(LEVELS - 1);
        return LW'(v);
    endfunction

    // memories
    t_value grid_mem [GDEPTH];
    t_value tab_mem  [TDEPTH];

    // configuration and flags
    t_cfg_val r_num_rows;
    t_cfg_val r_num_cols;
    logic     r_tab_ready;
    logic     w_cfg_wr;
    logic     w_accept;

    logic [RW-1:0] w_rows_m1;
    logic [CW-1:0] w_cols_m1;

    // captured query
    t_coord r_ra, r_ca, r_rb, r_cb;

    // build counters
    logic [RW-1:0] r_bi;
    logic [CW-1:0] r_bj;
    logic [LW-1:0] r_bk, r_bl;
    logic [RW-1:0] w_r2b;
    logic [CW-1:0] w_c2b;
    logic [LW-1:0] w_bk_m1, w_bl_m1;

    // query addressing
    logic [LW-1:0] w_ilog, w_jlog;
    logic [6:0]    w_r2q, w_c2q;
    logic [RW-1:0] w_qra, w_qr2;
    logic [CW-1:0] w_qca, w_qc2;
    logic          w_q_ok;

    logic [TAW-1:0] w_addr_a, w_addr_b, w_waddr;
    t_value         w_wdata, w_qmax;
    t_value         r_qa, r_qb, r_grid_q, r_acc;

    logic   r_out_valid;
    t_value r_out_max;
    logic   r_out_err;

    assign i_cfg.ready   = 1'b1;
    assign w_cfg_wr      = i_cfg.valid;
    assign i_item.ready  = i_cmd.in_ready;
    assign w_accept      = i_item.valid && i_cmd.in_ready;

    // effective dimensions minus one
    always_comb begin
        if (r_num_rows == '0) begin
            w_rows_m1 = '0;
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            w_rows_m1 = RW'(MAX_ROWS - 1);
        end else begin
            w_rows_m1 = RW'(r_num_rows - 7'd1);
        end
        if (r_num_cols == '0) begin
            w_cols_m1 = '0;
        end else if (32'(r_num_cols) > MAX_COLS) begin
            w_cols_m1 = CW'(MAX_COLS - 1);
        end else begin
            w_cols_m1 = CW'(r_num_cols - 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= CFG_RESET_DIM;
            r_num_cols  <= CFG_RESET_DIM;
            r_tab_ready <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                if (i_cfg.index == CFG_NUM_ROWS) begin
                    r_num_rows <= i_cfg.data;
                end else begin
                    r_num_cols <= i_cfg.data;
                end
            end
            if (w_cfg_wr || i_cmd.clr_ready) begin
                r_tab_ready <= 1'b0;
            end else if (i_cmd.set_ready) begin
                r_tab_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ra <= i_item.row_a;
            r_ca <= i_item.col_a;
            r_rb <= i_item.row_b;
            r_cb <= i_item.col_b;
        end
    end

    // grid: written on load accept, read during build
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_item.operation == OP_LOAD) && (32'(i_item.row_a) < MAX_ROWS)
            && (32'(i_item.col_a) < MAX_COLS)) begin
            grid_mem[GAW'(32'(i_item.row_a) * MAX_COLS + 32'(i_item.col_a))] <= i_item.cell_value;
        end
        if (i_cmd.rd_en) begin
            r_grid_q <= grid_mem[GAW'(32'(r_bi) * MAX_COLS + 32'(r_bj))];
        end
    end

    // build walk: rows and cols descending, row level then col level ascending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bi <= '0;
            r_bj <= '0;
            r_bk <= '0;
            r_bl <= '0;
        end else if (i_cmd.build_init) begin
            r_bi <= w_rows_m1;
            r_bj <= w_cols_m1;
            r_bk <= '0;
            r_bl <= '0;
        end else if (i_cmd.build_wr) begin
            if (32'(r_bl) != LEVELS - 1) begin
                r_bl <= r_bl + LW'(1);
            end else begin
                r_bl <= '0;
                if (32'(r_bk) != LEVELS - 1) begin
                    r_bk <= r_bk + LW'(1);
                end else begin
                    r_bk <= '0;
                    if (r_bj != '0) begin
                        r_bj <= r_bj - CW'(1);
                    end else begin
                        r_bj <= w_cols_m1;
                        r_bi <= r_bi - RW'(1);
                    end
                end
            end
        end
    end

    assign w_bk_m1 = r_bk - LW'(1);
    assign w_bl_m1 = r_bl - LW'(1);

    // neighbor block clamped to the last row / column in use
    always_comb begin
        if (32'(r_bi) + (32'd1 << w_bk_m1) > 32'(w_rows_m1)) begin
            w_r2b = w_rows_m1;
        end else begin
            w_r2b = RW'(32'(r_bi) + (32'd1 << w_bk_m1));
        end
        if (32'(r_bj) + (32'd1 << w_bl_m1) > 32'(w_cols_m1)) begin
            w_c2b = w_cols_m1;
        end else begin
            w_c2b = CW'(32'(r_bj) + (32'd1 << w_bl_m1));
        end
    end

    // query geometry
    assign w_ilog = lvl_clamp(floor_log2(7'(r_rb) - 7'(r_ra) + 7'd1));
    assign w_jlog = lvl_clamp(floor_log2(7'(r_cb) - 7'(r_ca) + 7'd1));
    assign w_r2q  = 7'(r_rb) + 7'd1 - (7'd1 << w_ilog);
    assign w_c2q  = 7'(r_cb) + 7'd1 - (7'd1 << w_jlog);
    assign w_qra  = RW'(r_ra);
    assign w_qca  = CW'(r_ca);
    assign w_qr2  = RW'(w_r2q);
    assign w_qc2  = CW'(w_c2q);
    assign w_q_ok = r_tab_ready && (r_ra <= r_rb) && (r_ca <= r_cb)
                    && (32'(r_rb) <= 32'(w_rows_m1)) && (32'(r_cb) <= 32'(w_cols_m1));

    always_comb begin
        case (i_cmd.rd_mode)
            RD_BUILD: begin
                if (r_bl == '0) begin
                    w_addr_a = tab_idx(r_bi, w_bk_m1, r_bj, '0);
                    w_addr_b = tab_idx(w_r2b, w_bk_m1, r_bj, '0);
                end else begin
                    w_addr_a = tab_idx(r_bi, r_bk, r_bj, w_bl_m1);
                    w_addr_b = tab_idx(r_bi, r_bk, w_c2b, w_bl_m1);
                end
            end
            RD_Q0: begin
                w_addr_a = tab_idx(w_qra, w_ilog, w_qca, w_jlog);
                w_addr_b = tab_idx(w_qr2, w_ilog, w_qca, w_jlog);
            end
            RD_Q1: begin
                w_addr_a = tab_idx(w_qra, w_ilog, w_qc2, w_jlog);
                w_addr_b = tab_idx(w_qr2, w_ilog, w_qc2, w_jlog);
            end
            default: begin
                w_addr_a = '0;
                w_addr_b = '0;
            end
        endcase
    end

    assign w_qmax  = (r_qa > r_qb) ? r_qa : r_qb;
    assign w_waddr = tab_idx(r_bi, r_bk, r_bj, r_bl);
    assign w_wdata = ((r_bk == '0) && (r_bl == '0)) ? r_grid_q : w_qmax;

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_wr) begin
            tab_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_qa <= tab_mem[w_addr_a];
            r_qb <= tab_mem[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_acc <= w_qmax;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_err <= !w_q_ok;
            r_out_max <= !w_q_ok ? '0 : ((r_acc > w_qmax) ? r_acc : w_qmax);
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.max_value = r_out_max;
    assign o_result.error     = r_out_err;

    assign o_stat.in_valid   = i_item.valid;
    assign o_stat.in_query   = (i_item.operation == OP_QUERY);
    assign o_stat.in_last    = i_item.last_cell;
    assign o_stat.build_last = (r_bi == '0) && (r_bj == '0) && (32'(r_bk) == LEVELS - 1)
                               && (32'(r_bl) == LEVELS - 1);
    assign o_stat.out_free   = !r_out_valid || o_result.ready;

endmodule

// ===== hdl/range_max_2d_sparse_table_core.sv =====
// Load item: written on accept; next item accepted on the following cycle.
// Query item: reads in S_QRD0 and S_QRD1, result loaded in S_QDONE when the
// output is free, next item accepted back in S_IDLE. Last-cell load: build
// reads (S_BRD) then writes (S_BWR) each of rows*cols*LEVELS^2 table entries.
// Reset (synchronous, active low): table not ready, both dimensions 64,
// grid and table memories keep their contents.
// ----------------------------------------------------------------------------
// range_max_2d_sparse_table_core
// 2D sparse table range maximum: grid load, table build and rectangle query.
// ----------------------------------------------------------------------------
module range_max_2d_sparse_table_core #(
    parameter int MAX_ROWS = rmst_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rmst_pkg::DEF_MAX_COLS,
    parameter int LEVELS   = rmst_pkg::DEF_LEVELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmst_in_if.sink    i_item,
    rmst_out_if.source o_result,
    rmst_cfg_if.sink   i_cfg
);
    import rmst_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rmst_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .LEVELS   (LEVELS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule
